>>> hw/rtl/mpes_pkg.sv
package mpes_pkg;

  localparam int unsigned PcW      = 4;
  localparam int unsigned RegAddrW = 5;

  typedef enum logic [1:0] {
    OP_INTEGRATE    = 2'd0,
    OP_SET_ANGLE    = 2'd1,
    OP_SET_VELOCITY = 2'd2,
    OP_NONE         = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_LOWER_LIMIT    = 3'd0,
    REG_UPPER_LIMIT    = 3'd1,
    REG_DAMPING_COEFF  = 3'd2,
    REG_DRIVE_GAIN     = 3'd3,
    REG_ENCODER_OFFSET = 3'd4,
    REG_HALL_TOLERANCE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [24:0]        time_step;
    logic signed [31:0] voltage;
    logic signed [31:0] new_value;
  } mpes_in_t;

  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] encoder_angle;
    logic               upper_switch;
    logic               lower_switch;
  } mpes_out_t;

  typedef struct packed {
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic signed [31:0] damping_coeff;
    logic signed [31:0] drive_gain;
    logic signed [31:0] encoder_offset;
    logic [30:0]        hall_tolerance;
  } cfg_t;

  localparam logic signed [31:0] LowerLimitRst    = 32'sd0;
  localparam logic signed [31:0] UpperLimitRst    = 32'sd35232154;
  localparam logic signed [31:0] DampingCoeffRst  = -32'sd534471770;
  localparam logic signed [31:0] DriveGainRst     = 32'sd113195876;
  localparam logic signed [31:0] EncoderOffsetRst = 32'sd0;
  localparam logic [30:0]        HallToleranceRst = 31'd167772;

  localparam logic signed [38:0] AccMax = {1'b0, {38{1'b1}}};
  localparam logic signed [38:0] AccMin = {1'b1, {38{1'b0}}};

  typedef enum logic [1:0] {
    MA_VEL    = 2'd0,
    MA_VOLT   = 2'd1,
    MA_ACC_HI = 2'd2,
    MA_ACC_LO = 2'd3
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_DAMP = 2'd0,
    MB_GAIN = 2'd1,
    MB_DT   = 2'd2
  } mul_b_e;

  typedef enum logic [3:0] {
    ALU_NONE     = 4'd0,
    ALU_P1       = 4'd1,
    ALU_ACC      = 4'd2,
    ALU_ANG      = 4'd3,
    ALU_HI       = 4'd4,
    ALU_COMMIT   = 4'd5,
    ALU_LOAD_ANG = 4'd6,
    ALU_LOAD_VEL = 4'd7,
    ALU_REPORT   = 4'd8
  } alu_e;

  typedef enum logic [1:0] {
    NX_SEQ      = 2'd0,
    NX_DISPATCH = 2'd1,
    NX_JUMP     = 2'd2,
    NX_END      = 2'd3
  } next_e;

  localparam logic [PcW-1:0] PcIntegrate = 4'd1;
  localparam logic [PcW-1:0] PcSetAngle  = 4'd6;
  localparam logic [PcW-1:0] PcSetVel    = 4'd7;
  localparam logic [PcW-1:0] PcReport    = 4'd8;

  typedef struct packed {
    mul_a_e         mul_a;
    mul_b_e         mul_b;
    alu_e           alu;
    next_e          nxt;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   fire;
    mul_a_e mul_a;
    mul_b_e mul_b;
    alu_e   alu;
  } ctrl_t;

  // microprogram: alu stage consumes the product of the previous step
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{mul_a: MA_VEL, mul_b: MB_DAMP, alu: ALU_NONE, nxt: NX_END, target: '0};
    case (pc)
      4'd0: w = '{MA_VEL,    MB_DAMP, ALU_NONE,     NX_DISPATCH, '0};
      4'd1: w = '{MA_VOLT,   MB_GAIN, ALU_P1,       NX_SEQ,      '0};
      4'd2: w = '{MA_VEL,    MB_DT,   ALU_ACC,      NX_SEQ,      '0};
      4'd3: w = '{MA_ACC_HI, MB_DT,   ALU_ANG,      NX_SEQ,      '0};
      4'd4: w = '{MA_ACC_LO, MB_DT,   ALU_HI,       NX_SEQ,      '0};
      4'd5: w = '{MA_VEL,    MB_DAMP, ALU_COMMIT,   NX_JUMP,     PcReport};
      4'd6: w = '{MA_VEL,    MB_DAMP, ALU_LOAD_ANG, NX_JUMP,     PcReport};
      4'd7: w = '{MA_VEL,    MB_DAMP, ALU_LOAD_VEL, NX_JUMP,     PcReport};
      4'd8: w = '{MA_VEL,    MB_DAMP, ALU_REPORT,   NX_END,      '0};
      default: w = '{MA_VEL, MB_DAMP, ALU_NONE,     NX_END,      '0};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/mpes_sequencer.sv
module mpes_sequencer
  import mpes_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  op_e   op_i,
  input  logic  hold_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  logic           busy_q, busy_d;
  op_e            op_q, op_d;
  ucode_t         word;
  logic           fire;

  assign word = ucode_rom(pc_q);
  assign fire = busy_q & ~hold_i;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    op_d   = op_q;
    if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
      op_d   = op_i;
    end else if (fire) begin
      case (word.nxt)
        NX_SEQ: begin
          pc_d = pc_q + 4'd1;
        end
        NX_DISPATCH: begin
          case (op_q)
            OP_INTEGRATE:    pc_d = PcIntegrate;
            OP_SET_ANGLE:    pc_d = PcSetAngle;
            OP_SET_VELOCITY: pc_d = PcSetVel;
            default:         pc_d = PcReport;
          endcase
        end
        NX_JUMP: begin
          pc_d = word.target;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
      op_q   <= OP_INTEGRATE;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
      op_q   <= op_d;
    end
  end

  assign busy_o       = busy_q;
  assign ctrl_o.fire  = fire;
  assign ctrl_o.mul_a = word.mul_a;
  assign ctrl_o.mul_b = word.mul_b;
  assign ctrl_o.alu   = word.alu;

endmodule

>>> hw/rtl/mpes_datapath.sv
module mpes_datapath
  import mpes_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  mpes_in_t  in_i,
  input  cfg_t      cfg_i,
  input  ctrl_t     ctrl_i,
  output mpes_out_t report_o
);

  logic [24:0]        dt_q;
  logic signed [31:0] volt_q;
  logic signed [31:0] nv_q;
  logic signed [65:0] prod_q;
  logic signed [39:0] t1_q;
  logic signed [38:0] acc_q;
  logic signed [34:0] na_q;
  logic signed [31:0] angc_q;
  logic signed [45:0] hi_q;
  logic signed [31:0] angle_q;
  logic signed [31:0] vel_q;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_d;

  always_comb begin
    case (ctrl_i.mul_a)
      MA_VEL:    mul_a = {vel_q[31], vel_q};
      MA_VOLT:   mul_a = {volt_q[31], volt_q};
      MA_ACC_HI: mul_a = {{13{acc_q[38]}}, acc_q[38:19]};
      MA_ACC_LO: mul_a = {14'b0, acc_q[18:0]};
      default:   mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      MB_DAMP: mul_b = {cfg_i.damping_coeff[31], cfg_i.damping_coeff};
      MB_GAIN: mul_b = {cfg_i.drive_gain[31], cfg_i.drive_gain};
      MB_DT:   mul_b = {8'b0, dt_q};
      default: mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // acceleration sum, saturated to q15.24
  logic signed [39:0] p_q24;
  logic signed [40:0] acc_sum;
  logic signed [38:0] acc_sat;

  assign p_q24   = prod_q[63:24];
  assign acc_sum = {t1_q[39], t1_q} + {p_q24[39], p_q24};

  always_comb begin
    if (acc_sum[40:38] == 3'b000 || acc_sum[40:38] == 3'b111) begin
      acc_sat = acc_sum[38:0];
    end else if (acc_sum[40]) begin
      acc_sat = AccMin;
    end else begin
      acc_sat = AccMax;
    end
  end

  // angle update and clamp
  logic signed [34:0] ang_sum;
  logic signed [34:0] up35;
  logic signed [34:0] lo35;
  logic signed [34:0] clamp_a;
  logic signed [34:0] clamp_b;

  assign ang_sum = {{3{angle_q[31]}}, angle_q} + {prod_q[57], prod_q[57:24]};
  assign up35    = {{3{cfg_i.upper_limit[31]}}, cfg_i.upper_limit};
  assign lo35    = {{3{cfg_i.lower_limit[31]}}, cfg_i.lower_limit};
  assign clamp_a = (na_q > up35) ? up35 : na_q;
  assign clamp_b = (clamp_a < lo35) ? lo35 : clamp_a;

  // velocity update from split acc * dt
  logic signed [65:0] hi_ext;
  logic signed [65:0] lo_ext;
  logic signed [65:0] dv_full;
  logic signed [42:0] vel_sum;
  logic signed [31:0] vel_sat;

  assign hi_ext  = {{20{hi_q[45]}}, hi_q};
  assign lo_ext  = {{20{prod_q[45]}}, prod_q[45:0]};
  assign dv_full = (hi_ext <<< 19) + lo_ext;
  assign vel_sum = {{11{vel_q[31]}}, vel_q} + {dv_full[65], dv_full[65:24]};

  always_comb begin
    if (vel_sum[42:31] == 12'h000 || vel_sum[42:31] == 12'hfff) begin
      vel_sat = vel_sum[31:0];
    end else if (vel_sum[42]) begin
      vel_sat = {1'b1, 31'b0};
    end else begin
      vel_sat = {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dt_q   <= in_i.time_step;
      volt_q <= in_i.voltage;
      nv_q   <= in_i.new_value;
    end
    if (ctrl_i.fire) begin
      prod_q <= prod_d;
      case (ctrl_i.alu)
        ALU_P1:  t1_q   <= p_q24;
        ALU_ACC: acc_q  <= acc_sat;
        ALU_ANG: na_q   <= ang_sum;
        ALU_HI: begin
          hi_q   <= prod_q[45:0];
          angc_q <= clamp_b[31:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      vel_q   <= '0;
    end else if (ctrl_i.fire) begin
      case (ctrl_i.alu)
        ALU_COMMIT: begin
          angle_q <= angc_q;
          vel_q   <= vel_sat;
        end
        ALU_LOAD_ANG: angle_q <= nv_q;
        ALU_LOAD_VEL: vel_q   <= nv_q;
        default: ;
      endcase
    end
  end

  // report fields
  logic signed [32:0] enc_sum;
  logic signed [32:0] du;
  logic signed [32:0] dl;
  logic [32:0]        du_abs;
  logic [32:0]        dl_abs;
  logic [32:0]        tol33;

  assign enc_sum = {angle_q[31], angle_q} + {cfg_i.encoder_offset[31], cfg_i.encoder_offset};
  assign du      = {angle_q[31], angle_q} - {cfg_i.upper_limit[31], cfg_i.upper_limit};
  assign dl      = {angle_q[31], angle_q} - {cfg_i.lower_limit[31], cfg_i.lower_limit};
  assign du_abs  = du[32] ? (~du + 33'd1) : du;
  assign dl_abs  = dl[32] ? (~dl + 33'd1) : dl;
  assign tol33   = {2'b0, cfg_i.hall_tolerance};

  always_comb begin
    report_o.angle_out    = angle_q;
    report_o.velocity_out = vel_q;
    if (enc_sum[32] == enc_sum[31]) begin
      report_o.encoder_angle = enc_sum[31:0];
    end else if (enc_sum[32]) begin
      report_o.encoder_angle = {1'b1, 31'b0};
    end else begin
      report_o.encoder_angle = {1'b0, {31{1'b1}}};
    end
    report_o.upper_switch = (du_abs < tol33);
    report_o.lower_switch = (dl_abs < tol33);
  end

endmodule

>>> hw/rtl/motor_plant_euler_step_unit.sv
// channel   direction  payload     handshake
// in        sink       mpes_in_t   in_valid_i / in_stall_o
// out       source     mpes_out_t  out_valid_o / out_stall_i
// cfg       apb slave  32-bit      psel, penable, pwrite, pready
//
// one step of the microprogram per cycle while the report step is not held
// by a stalled output; five integrate steps share the single 33x33
// multiplier
// one transaction in flight; the next is taken once the result is registered
// a stalled output holds the report step until the result register drains
// reset clears the joint state to zero and the registers to their defaults
module motor_plant_euler_step_unit
  import mpes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpes_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpes_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t      cfg_q;
  logic      busy;
  logic      start;
  logic      hold;
  ctrl_t     ctrl;
  mpes_out_t report;
  logic      out_valid_q;
  mpes_out_t out_data_q;
  reg_idx_e  reg_idx;

  assign reg_idx = reg_idx_e'(paddr[RegAddrW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_limit    <= LowerLimitRst;
      cfg_q.upper_limit    <= UpperLimitRst;
      cfg_q.damping_coeff  <= DampingCoeffRst;
      cfg_q.drive_gain     <= DriveGainRst;
      cfg_q.encoder_offset <= EncoderOffsetRst;
      cfg_q.hall_tolerance <= HallToleranceRst;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_LOWER_LIMIT:    cfg_q.lower_limit    <= pwdata;
        REG_UPPER_LIMIT:    cfg_q.upper_limit    <= pwdata;
        REG_DAMPING_COEFF:  cfg_q.damping_coeff  <= pwdata;
        REG_DRIVE_GAIN:     cfg_q.drive_gain     <= pwdata;
        REG_ENCODER_OFFSET: cfg_q.encoder_offset <= pwdata;
        REG_HALL_TOLERANCE: cfg_q.hall_tolerance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOWER_LIMIT:    prdata = cfg_q.lower_limit;
      REG_UPPER_LIMIT:    prdata = cfg_q.upper_limit;
      REG_DAMPING_COEFF:  prdata = cfg_q.damping_coeff;
      REG_DRIVE_GAIN:     prdata = cfg_q.drive_gain;
      REG_ENCODER_OFFSET: prdata = cfg_q.encoder_offset;
      REG_HALL_TOLERANCE: prdata = {1'b0, cfg_q.hall_tolerance};
      default:            prdata = '0;
    endcase
  end

  assign in_stall_o = busy;
  assign start      = in_valid_i & ~busy;
  assign hold       = (ctrl.alu == ALU_REPORT) & out_valid_q & out_stall_i;

  mpes_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op_e'(in_data_i.operation)),
    .hold_i  (hold),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  mpes_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .in_i     (in_data_i),
    .cfg_i    (cfg_q),
    .ctrl_i   (ctrl),
    .report_o (report)
  );

  logic report_fire;
  assign report_fire = ctrl.fire & (ctrl.alu == ALU_REPORT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (report_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report_fire) begin
      out_data_q <= report;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/mpes_checker.sv
module mpes_checker
  import mpes_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input mpes_out_t out_data_o
);

  // every transaction keeps the block busy, stalling the input, after it is accepted
  a_min_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##1 in_stall_o ##1 in_stall_o)
    else $error("input accepted again too soon");

  // a result only appears at the end of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in progress");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

endmodule

bind motor_plant_euler_step_unit mpes_checker u_mpes_checker (.*);

>>> sim/tb_motor_plant_euler_step_unit.sv
module tb_motor_plant_euler_step_unit;
  import mpes_pkg::*;

  localparam logic [31:0] QMax       = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin       = 32'h8000_0000;
  localparam longint      AccTop     = 64'sd274877906943;
  localparam longint      AccBottom  = -64'sd274877906944;
  localparam int          OneSecond  = 1 << 24;
  localparam int          FullStep   = 33554431;
  localparam int          NumPhases  = 8;
  localparam int          PhaseItems = 212;
  localparam int          QuietLimit = 4000;

  typedef struct packed {
    logic      is_cfg;
    reg_idx_e  idx;
    logic [31:0] value;
    mpes_in_t  item;
    logic      typed;
    mpes_out_t known;
  } step_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  mpes_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  mpes_out_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [RegAddrW-1:0] paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  // joint state and register copies seen by the predictor
  int     joint_pos  = 0;
  int     joint_rate = 0;
  int     lim_lo     = LowerLimitRst;
  int     lim_hi     = UpperLimitRst;
  int     damp_k     = DampingCoeffRst;
  int     gain_k     = DriveGainRst;
  int     enc_off    = EncoderOffsetRst;
  longint switch_tol = longint'(HallToleranceRst);

  mpes_out_t   pending_reports[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          sending      = 1'b0;
  bit          steady       = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned stall_mode   = 0;
  int unsigned stall_hold   = 0;

  motor_plant_euler_step_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int clamp32(input longint x);
    if (x > longint'(int'(QMax))) return int'(QMax);
    if (x < longint'(int'(QMin))) return int'(QMin);
    return int'(x);
  endfunction

  function automatic longint distance(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int spread(input int unsigned r);
    return int'($urandom_range(0, 2 * r)) - int'(r);
  endfunction

  function automatic mpes_out_t advance_joint(input mpes_in_t it);
    longint    pos, rate, dt, accel, next_pos, next_rate;
    int        volt, load;
    mpes_out_t rep;
    pos  = joint_pos;
    rate = joint_rate;
    dt   = longint'(it.time_step);
    volt = it.voltage;
    load = it.new_value;
    case (op_e'(it.operation))
      OP_INTEGRATE: begin
        accel = ((rate * damp_k) >>> 24) + ((longint'(volt) * gain_k) >>> 24);
        if (accel > AccTop) accel = AccTop;
        if (accel < AccBottom) accel = AccBottom;
        next_pos  = pos + ((rate * dt) >>> 24);
        next_rate = rate + ((accel * dt) >>> 24);
        if (next_pos > lim_hi) next_pos = lim_hi;
        if (next_pos < lim_lo) next_pos = lim_lo;
        joint_pos  = int'(next_pos);
        joint_rate = clamp32(next_rate);
      end
      OP_SET_ANGLE:    joint_pos = load;
      OP_SET_VELOCITY: joint_rate = load;
      default: ;
    endcase
    pos = joint_pos;
    rep.angle_out     = joint_pos;
    rep.velocity_out  = joint_rate;
    rep.encoder_angle = clamp32(pos + enc_off);
    rep.upper_switch  = distance(pos, lim_hi) < switch_tol;
    rep.lower_switch  = distance(pos, lim_lo) < switch_tol;
    return rep;
  endfunction

  function automatic step_row_t op_row(input op_e op, input int dt, input int volt,
                                       input int nv);
    step_row_t r;
    r = '0;
    r.item.operation = op;
    r.item.time_step = 25'(dt);
    r.item.voltage   = volt;
    r.item.new_value = nv;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input reg_idx_e idx, input logic [31:0] v);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    return r;
  endfunction

  function automatic step_row_t pinned(input step_row_t r, input int a, input int v,
                                       input int e, input logic up, input logic lo);
    step_row_t p;
    p = r;
    p.typed = 1'b1;
    p.known.angle_out     = a;
    p.known.velocity_out  = v;
    p.known.encoder_angle = e;
    p.known.upper_switch  = up;
    p.known.lower_switch  = lo;
    return p;
  endfunction

  function automatic mpes_in_t random_item();
    mpes_in_t    it;
    int unsigned pick;
    it.operation = OP_NONE;
    it.time_step = 25'($urandom());
    it.voltage   = $urandom();
    it.new_value = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      it.operation = OP_INTEGRATE;
      case ($urandom_range(0, 9))
        7: it.time_step = 25'($urandom_range(0, OneSecond));
        8: it.time_step = 25'($urandom());
        9: it.time_step = ($urandom_range(0, 2) == 0) ? 25'(0) :
                          ($urandom_range(0, 1) ? 25'(OneSecond) : 25'(FullStep));
        default: it.time_step = 25'($urandom_range(0, 1 << 20));
      endcase
      case ($urandom_range(0, 9))
        8: it.voltage = $urandom();
        9: it.voltage = $urandom_range(0, 1) ? QMax : QMin;
        default: it.voltage = spread(24 << 24);
      endcase
    end else if (pick < 80) begin
      it.operation = OP_SET_ANGLE;
      case ($urandom_range(0, 3))
        0: it.new_value = lim_lo + spread(1 << 18);
        1: it.new_value = lim_hi + spread(1 << 18);
        2: it.new_value = spread(4 << 24);
        default: it.new_value = $urandom();
      endcase
    end else if (pick < 92) begin
      it.operation = OP_SET_VELOCITY;
      case ($urandom_range(0, 3))
        0: it.new_value = spread(1 << 24);
        3: it.new_value = $urandom();
        default: it.new_value = spread(8 << 24);
      endcase
    end
    return it;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOWER_LIMIT:    lim_lo = val;
      REG_UPPER_LIMIT:    lim_hi = val;
      REG_DAMPING_COEFF:  damp_k = val;
      REG_DRIVE_GAIN:     gain_k = val;
      REG_ENCODER_OFFSET: enc_off = val;
      REG_HALL_TOLERANCE: switch_tol = longint'(val[30:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic offer(input mpes_in_t it, input logic typed, input mpes_out_t known);
    mpes_out_t want;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    sending = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    want = advance_joint(it);
    pending_reports.push_back(typed ? known : want);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_valid_i <= 1'b0;
        sending = 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic go_idle();
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
    end
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_phase(input int ph);
    logic [31:0] lo, hi, damp, gain, enc, tol, tmp;
    case (ph)
      0: begin
        lo = LowerLimitRst;  hi = UpperLimitRst;    damp = DampingCoeffRst;
        gain = DriveGainRst; enc = EncoderOffsetRst; tol = {1'b0, HallToleranceRst};
      end
      1: begin
        lo = QMin; hi = QMax; damp = QMin; gain = QMax; enc = QMin; tol = '0;
      end
      2: begin
        lo = QMax; hi = QMin; damp = QMax; gain = QMin; enc = QMax; tol = 32'h7FFF_FFFF;
      end
      default: begin
        lo = -int'($urandom_range(0, 4 << 24));
        hi = $urandom_range(0, 4 << 24);
        if ($urandom_range(0, 5) == 0) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        damp = -int'($urandom_range(0, 64 << 24));
        gain = spread(16 << 24);
        enc  = $urandom_range(0, 1) ? spread(1 << 24) : $urandom();
        tol  = $urandom_range(0, 1 << 22);
      end
    endcase
    write_reg(REG_LOWER_LIMIT, lo);
    write_reg(REG_UPPER_LIMIT, hi);
    write_reg(REG_DAMPING_COEFF, damp);
    write_reg(REG_DRIVE_GAIN, gain);
    write_reg(REG_ENCODER_OFFSET, enc);
    write_reg(REG_HALL_TOLERANCE, tol);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    mpes_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("angle_out", want.angle_out, out_data_o.angle_out);
        check_field("velocity_out", want.velocity_out, out_data_o.velocity_out);
        check_field("encoder_angle", want.encoder_angle, out_data_o.encoder_angle);
        check_field("upper_switch", {31'b0, want.upper_switch},
                    {31'b0, out_data_o.upper_switch});
        check_field("lower_switch", {31'b0, want.lower_switch},
                    {31'b0, out_data_o.lower_switch});
      end
    end
  end

  // receiver back-pressure: free-running, random, or long periodic stalls
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(50, 400);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 35);
      default: out_stall_i <= ((stall_hold % 11) < 7);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL motor_plant_euler_step_unit");
    $finish;
  end

  initial begin
    step_row_t plan[$];
    step_row_t row;
    plan.push_back(pinned(op_row(OP_NONE, 0, 0, 0), 0, 0, 0, 1'b0, 1'b1));
    plan.push_back(pinned(op_row(OP_SET_ANGLE, 0, 0, QMax), QMax, 0, QMax, 1'b0, 1'b0));
    plan.push_back(pinned(op_row(OP_SET_ANGLE, 0, 0, QMin), QMin, 0, QMin, 1'b0, 1'b0));
    plan.push_back(pinned(op_row(OP_SET_VELOCITY, 0, 0, QMax), QMin, QMax, QMin,
                          1'b0, 1'b0));
    // zero step: angle is pulled up to the lower limit, velocity kept
    plan.push_back(pinned(op_row(OP_INTEGRATE, 0, 0, 0), 0, QMax, 0, 1'b0, 1'b1));
    plan.push_back(op_row(OP_INTEGRATE, OneSecond, QMax, 0));
    plan.push_back(op_row(OP_INTEGRATE, FullStep, QMin, 0));
    plan.push_back(op_row(OP_SET_VELOCITY, 0, 0, QMin));
    plan.push_back(op_row(OP_INTEGRATE, FullStep, QMax, 0));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0, UpperLimitRst));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0,
                          int'(UpperLimitRst) - int'(HallToleranceRst)));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0,
                          int'(UpperLimitRst) - int'(HallToleranceRst) + 1));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0, -int'(HallToleranceRst) + 1));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0, -int'(HallToleranceRst)));
    // acceleration saturation in both directions
    plan.push_back(cfg_row(REG_DAMPING_COEFF, QMin));
    plan.push_back(cfg_row(REG_DRIVE_GAIN, QMax));
    plan.push_back(op_row(OP_SET_VELOCITY, 0, 0, QMin));
    plan.push_back(op_row(OP_INTEGRATE, FullStep, QMax, 0));
    plan.push_back(op_row(OP_INTEGRATE, FullStep, QMin, 0));
    // crossed limits, saturated encoder, widest switch window
    plan.push_back(cfg_row(REG_UPPER_LIMIT, QMin));
    plan.push_back(cfg_row(REG_LOWER_LIMIT, QMax));
    plan.push_back(cfg_row(REG_ENCODER_OFFSET, QMax));
    plan.push_back(cfg_row(REG_HALL_TOLERANCE, 32'h7FFF_FFFF));
    plan.push_back(op_row(OP_INTEGRATE, OneSecond, 0, 0));
    plan.push_back(op_row(OP_SET_ANGLE, 0, 0, 0));
    plan.push_back(op_row(OP_NONE, 0, 0, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        go_idle();
        write_reg(row.idx, row.value);
      end else begin
        offer(row.item, row.typed, row.known);
        pace();
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      go_idle();
      load_phase(ph);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PhaseItems; n++) begin
        offer(random_item(), 1'b0, '0);
        pace();
      end
    end

    go_idle();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS motor_plant_euler_step_unit");
    end else begin
      $display("FAIL motor_plant_euler_step_unit");
    end
    $finish;
  end

endmodule

>>> motor_plant_euler_step_unit.f
hw/rtl/mpes_pkg.sv
hw/rtl/mpes_sequencer.sv
hw/rtl/mpes_datapath.sv
hw/rtl/motor_plant_euler_step_unit.sv
hw/rtl/mpes_checker.sv
sim/tb_motor_plant_euler_step_unit.sv
